// ===== design/lcm_pkg.sv =====
// Shared types, constants and the microcode ROM of the least common multiple unit.
package lcm_pkg;

    localparam int LCM_OPERAND_WIDTH = 32;
    localparam int LCM_OUT_WIDTH     = 64;
    localparam int LCM_PC_WIDTH      = 4;

    typedef logic [LCM_PC_WIDTH-1:0] t_upc;

    // Datapath action selected by a control word
    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_LOAD    = 3'd1,  // take an input beat
        OP_SPECIAL = 3'd2,  // result for zero or equal operands
        OP_DIV_EUC = 3'd3,  // start divider on y / x
        OP_SWAP    = 3'd4,  // y <= x, x <= remainder
        OP_DIV_FIN = 3'd5,  // start divider on a / gcd
        OP_MUL     = 3'd6,  // result <= quotient * b
        OP_EMIT    = 3'd7   // move result to the output register
    } t_op;

    // Jump condition: taken when true, otherwise fall through to pc + 1
    typedef enum logic [2:0] {
        C_NEVER       = 3'd0,
        C_ALWAYS      = 3'd1,
        C_NO_IN       = 3'd2,
        C_SPECIAL     = 3'd3,
        C_X_ZERO      = 3'd4,
        C_DIV_BUSY    = 3'd5,
        C_OUT_BLOCKED = 3'd6
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // Step addresses
    localparam t_upc ST_IDLE     = 4'd0;
    localparam t_upc ST_CHECK    = 4'd1;
    localparam t_upc ST_EUC_TEST = 4'd2;
    localparam t_upc ST_EUC_DIV  = 4'd3;
    localparam t_upc ST_EUC_WAIT = 4'd4;
    localparam t_upc ST_EUC_SWAP = 4'd5;
    localparam t_upc ST_FIN_DIV  = 4'd6;
    localparam t_upc ST_FIN_WAIT = 4'd7;
    localparam t_upc ST_MUL      = 4'd8;
    localparam t_upc ST_OUT_WAIT = 4'd9;
    localparam t_upc ST_EMIT     = 4'd10;

    // Microcode ROM
    function automatic t_uword lcm_rom(input t_upc pc);
        t_uword w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_IDLE};
        unique case (pc)
            ST_IDLE:     w = '{op: OP_LOAD,    cond: C_NO_IN,       target: ST_IDLE};
            ST_CHECK:    w = '{op: OP_SPECIAL, cond: C_SPECIAL,     target: ST_OUT_WAIT};
            ST_EUC_TEST: w = '{op: OP_NOP,     cond: C_X_ZERO,      target: ST_FIN_DIV};
            ST_EUC_DIV:  w = '{op: OP_DIV_EUC, cond: C_NEVER,       target: ST_IDLE};
            ST_EUC_WAIT: w = '{op: OP_NOP,     cond: C_DIV_BUSY,    target: ST_EUC_WAIT};
            ST_EUC_SWAP: w = '{op: OP_SWAP,    cond: C_ALWAYS,      target: ST_EUC_TEST};
            ST_FIN_DIV:  w = '{op: OP_DIV_FIN, cond: C_NEVER,       target: ST_IDLE};
            ST_FIN_WAIT: w = '{op: OP_NOP,     cond: C_DIV_BUSY,    target: ST_FIN_WAIT};
            ST_MUL:      w = '{op: OP_MUL,     cond: C_NEVER,       target: ST_IDLE};
            ST_OUT_WAIT: w = '{op: OP_NOP,     cond: C_OUT_BLOCKED, target: ST_OUT_WAIT};
            ST_EMIT:     w = '{op: OP_EMIT,    cond: C_ALWAYS,      target: ST_IDLE};
            default:     w = '{op: OP_NOP,     cond: C_ALWAYS,      target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== design/lcm_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
module lcm_div #(
    parameter int OPERAND_WIDTH = lcm_pkg::LCM_OPERAND_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [OPERAND_WIDTH-1:0] i_dividend,
    input  logic [OPERAND_WIDTH-1:0] i_divisor,
    output logic [OPERAND_WIDTH-1:0] o_quotient,
    output logic [OPERAND_WIDTH-1:0] o_remainder,
    output logic                     o_busy
);

    localparam int W    = OPERAND_WIDTH;
    localparam int CntW = $clog2(W + 1);

    logic [W-1:0]    r_rem, n_rem;
    logic [W-1:0]    r_quo, n_quo;
    logic [W-1:0]    r_dsr;
    logic [CntW-1:0] r_cnt;

    logic [W:0] shifted;
    logic [W:0] diff;

    // One restoring step: shift in the next dividend bit, try subtracting
    always_comb begin
        shifted = {r_rem, r_quo[W-1]};
        diff    = shifted - {1'b0, r_dsr};
        if (diff[W]) begin
            n_rem = shifted[W-1:0];
            n_quo = {r_quo[W-2:0], 1'b0};
        end else begin
            n_rem = diff[W-1:0];
            n_quo = {r_quo[W-2:0], 1'b1};
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CntW'(W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CntW'(1);
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_busy      = (r_cnt != '0);

endmodule

// ===== design/least_common_multiple_unit.sv =====
// Top level: microcoded least common multiple unit (Euclid gcd, divide, multiply).
//
//  channel  | direction | handshake                   | beat contents
//  ---------+-----------+-----------------------------+-------------------------------
//  in       | to unit   | i_in_valid / o_in_stall     | i_operand_a, i_operand_b
//  out      | from unit | o_out_valid / i_out_stall   | o_multiple
//
//  Zero or equal operands skip the Euclid rounds and both divisions; any other
//  beat runs the Euclid rounds, then the final a / gcd division and the multiply.
//  Every round and the final a / gcd run through the one bit-per-cycle divider.
//  Reset clears the step counter, divider counter and output valid.
//  A new beat is taken only at the idle step; a stalled result waits in the
//  output register while the sequencer holds before its emit step.
module least_common_multiple_unit #(
    parameter int OPERAND_WIDTH = lcm_pkg::LCM_OPERAND_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [OPERAND_WIDTH-1:0]            i_operand_a,
    input  logic [OPERAND_WIDTH-1:0]            i_operand_b,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [lcm_pkg::LCM_OUT_WIDTH-1:0]   o_multiple
);

    localparam int W    = OPERAND_WIDTH;
    localparam int OutW = lcm_pkg::LCM_OUT_WIDTH;

    lcm_pkg::t_upc   r_pc, n_pc;
    lcm_pkg::t_uword uw;

    logic [W-1:0]      r_a, r_b, r_x, r_y;
    logic [OutW-1:0]   r_res;
    logic [OutW-1:0]   r_out;
    logic              r_out_valid;

    logic              in_accept;
    logic              out_accept;
    logic              special;
    logic              jump;

    logic              div_start;
    logic [W-1:0]      div_dividend, div_divisor;
    logic [W-1:0]      div_quo, div_rem;
    logic              div_busy;
    logic [2*W-1:0]    mul_prod;

    // Control word fetch
    assign uw = lcm_pkg::lcm_rom(r_pc);

    // Handshake
    assign o_in_stall = (uw.op != lcm_pkg::OP_LOAD);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_accept = r_out_valid && !i_out_stall;

    assign special = (r_a == '0) || (r_b == '0) || (r_a == r_b);

    // Jump condition select
    always_comb begin
        unique case (uw.cond)
            lcm_pkg::C_NEVER:       jump = 1'b0;
            lcm_pkg::C_ALWAYS:      jump = 1'b1;
            lcm_pkg::C_NO_IN:       jump = !in_accept;
            lcm_pkg::C_SPECIAL:     jump = special;
            lcm_pkg::C_X_ZERO:      jump = (r_x == '0);
            lcm_pkg::C_DIV_BUSY:    jump = div_busy;
            lcm_pkg::C_OUT_BLOCKED: jump = r_out_valid && i_out_stall;
            default:                jump = 1'b1;
        endcase
        n_pc = jump ? uw.target : r_pc + lcm_pkg::t_upc'(1);
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= lcm_pkg::ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Divider hookup
    assign div_start    = (uw.op == lcm_pkg::OP_DIV_EUC) || (uw.op == lcm_pkg::OP_DIV_FIN);
    assign div_dividend = (uw.op == lcm_pkg::OP_DIV_EUC) ? r_y : r_a;
    assign div_divisor  = (uw.op == lcm_pkg::OP_DIV_EUC) ? r_x : r_y;

    lcm_div #(
        .OPERAND_WIDTH (W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_quotient  (div_quo),
        .o_remainder (div_rem),
        .o_busy      (div_busy)
    );

    assign mul_prod = (2*W)'(div_quo) * (2*W)'(r_b);

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (uw.op)
            lcm_pkg::OP_LOAD: begin
                if (in_accept) begin
                    r_a <= i_operand_a;
                    r_b <= i_operand_b;
                    r_x <= i_operand_a;
                    r_y <= i_operand_b;
                end
            end
            lcm_pkg::OP_SPECIAL: begin
                r_res <= (r_a == '0) ? OutW'(r_b) : OutW'(r_a);
            end
            lcm_pkg::OP_SWAP: begin
                r_y <= r_x;
                r_x <= div_rem;
            end
            lcm_pkg::OP_MUL: begin
                r_res <= OutW'(mul_prod);
            end
            lcm_pkg::OP_EMIT: begin
                r_out <= r_res;
            end
            default: begin
            end
        endcase
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.op == lcm_pkg::OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_multiple  = r_out;

`ifndef NO_ASSERTIONS
    // Emit never overwrites a result still waiting at the output
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == lcm_pkg::ST_EMIT) |-> !r_out_valid)
        else $error("emit while output register full");

    // Divider is never restarted mid-division
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // Accepted beat goes straight to the operand check
    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_pc == lcm_pkg::ST_CHECK))
        else $error("sequencer did not advance after input beat");

    // Euclid remainder is below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == lcm_pkg::ST_EUC_SWAP) |-> (div_rem < r_x))
        else $error("Euclid remainder not below divisor");

    // The gcd divides operand a exactly
    a_gcd_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == lcm_pkg::ST_MUL) |-> (div_rem == '0))
        else $error("gcd does not divide operand a");
`endif

endmodule
